[src/jsu_pkg.sv]
package jsu_pkg;

   localparam int unsigned JSU_QUEUE_DEPTH = 4;
   localparam int unsigned JSU_MAX_RESULTS = 4;

   localparam logic [1:0] ST_DATA  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   typedef struct packed {
      logic [JSU_MAX_RESULTS-1:0][7:0] data;
      logic [2:0]                      count;
      logic [1:0]                      status;
   } rec_type;

endpackage

[src/jsu_front.sv]
module jsu_front
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       q_full,
   output logic       q_push,
   output rec_type    q_rec
);

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_STR     = 3'd1,
      M_ESC     = 3'd2,
      M_HEX_HI  = 3'd3,
      M_WANT_BS = 3'd4,
      M_WANT_U  = 3'd5,
      M_HEX_LO  = 3'd6
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  hh_ff, hh_in;
   rec_type     rec;
   logic        accept;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] v;
   logic [20:0] cp_pair;

   function automatic rec_type utf8_rec(input logic [20:0] cp);
      rec_type r;
      r = '0;
      r.status = ST_DATA;
      if (cp < 21'h80) begin
         r.data[0] = cp[7:0];
         r.count   = 3'd1;
      end else if (cp < 21'h800) begin
         r.data[0] = {3'b110, cp[10:6]};
         r.data[1] = {2'b10, cp[5:0]};
         r.count   = 3'd2;
      end else if (cp < 21'h10000) begin
         r.data[0] = {4'b1110, cp[15:12]};
         r.data[1] = {2'b10, cp[11:6]};
         r.data[2] = {2'b10, cp[5:0]};
         r.count   = 3'd3;
      end else begin
         r.data[0] = {5'b11110, cp[20:18]};
         r.data[1] = {2'b10, cp[17:12]};
         r.data[2] = {2'b10, cp[11:6]};
         r.data[3] = {2'b10, cp[5:0]};
         r.count   = 3'd4;
      end
      return r;
   endfunction

   function automatic rec_type one_rec(input logic [7:0] b, input logic [1:0] st);
      rec_type r;
      r = '0;
      r.data[0] = b;
      r.status  = st;
      r.count   = 3'd1;
      return r;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign v         = {acc_ff, hex_val};
   assign cp_pair   = {({1'b0, hh_ff} + 11'd64), v[9:0]};

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      case (req_in_byte) inside
         [8'h30:8'h39]: hex_val = req_in_byte[3:0];
         [8'h61:8'h66], [8'h41:8'h46]: hex_val = req_in_byte[3:0] + 4'd9;
         default: hex_ok = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      hh_in   = hh_ff;
      rec     = '0;
      case (mode_ff)
         M_STR: begin
            if (req_in_byte == CH_QUOTE) begin
               rec = one_rec(8'h00, ST_DONE);
            end else if (req_in_byte == CH_BACKSLASH) begin
               mode_in = M_ESC;
            end else if (req_in_byte == 8'h00) begin
               rec = one_rec(8'h00, ST_ERROR);
            end else begin
               rec = one_rec(req_in_byte, ST_DATA);
            end
         end
         M_ESC: begin
            mode_in = M_STR;
            case (req_in_byte)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: rec = one_rec(req_in_byte, ST_DATA);
               CH_B: rec = one_rec(8'h08, ST_DATA);
               CH_F: rec = one_rec(8'h0C, ST_DATA);
               CH_N: rec = one_rec(8'h0A, ST_DATA);
               CH_R: rec = one_rec(8'h0D, ST_DATA);
               CH_T: rec = one_rec(8'h09, ST_DATA);
               CH_U: begin
                  mode_in = M_HEX_HI;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
               default: rec = one_rec(8'h00, ST_ERROR);
            endcase
         end
         M_HEX_HI, M_HEX_LO: begin
            if (!hex_ok) begin
               rec = one_rec(8'h00, ST_ERROR);
            end else if (cnt_ff != 2'd3) begin
               acc_in = v[11:0];
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               if (mode_ff == M_HEX_HI) begin
                  if (v[15:10] == 6'b110110) begin
                     hh_in   = v[9:0];
                     mode_in = M_WANT_BS;
                  end else if (v[15:10] == 6'b110111 || v == 16'hFFFF) begin
                     rec = one_rec(8'h00, ST_ERROR);
                  end else begin
                     mode_in = M_STR;
                     rec     = utf8_rec({5'h00, v});
                  end
               end else begin
                  if (v[15:10] != 6'b110111 || cp_pair[15:0] == 16'hFFFF) begin
                     rec = one_rec(8'h00, ST_ERROR);
                  end else begin
                     hh_in   = '0;
                     mode_in = M_STR;
                     rec     = utf8_rec(cp_pair);
                  end
               end
            end
         end
         M_WANT_BS: begin
            if (req_in_byte != CH_BACKSLASH) begin
               rec = one_rec(8'h00, ST_ERROR);
            end else begin
               mode_in = M_WANT_U;
            end
         end
         M_WANT_U: begin
            if (req_in_byte != CH_U) begin
               rec = one_rec(8'h00, ST_ERROR);
            end else begin
               mode_in = M_HEX_LO;
               acc_in  = '0;
               cnt_in  = '0;
            end
         end
         default: begin
            mode_in = M_IDLE;
            acc_in  = '0;
            cnt_in  = '0;
            hh_in   = '0;
            if (req_in_byte == CH_SPACE ||
                (req_in_byte >= 8'h09 && req_in_byte <= 8'h0D)) begin
               rec = '0;
            end else if (req_in_byte == CH_QUOTE) begin
               mode_in = M_STR;
            end else begin
               rec = one_rec(8'h00, ST_ERROR);
            end
         end
      endcase
      if (rec.status != ST_DATA) begin
         mode_in = M_IDLE;
         acc_in  = '0;
         cnt_in  = '0;
         hh_in   = '0;
      end
   end

   assign q_push = accept && (rec.count != 3'd0);
   assign q_rec  = rec;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         hh_ff   <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         hh_ff   <= hh_in;
      end
   end

endmodule

[src/jsu_queue.sv]
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int unsigned Depth = JSU_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output rec_type pop_rec
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   rec_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == CntFull);
   assign valid   = (cnt_ff != '0);
   assign pop_rec = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[src/jsu_back.sv]
module jsu_back
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  rec_type    q_rec,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   rec_type    cur_ff;
   logic [1:0] idx_ff;
   logic       valid_ff;
   logic       last;
   logic       xfer;
   logic       load;

   assign last = ({1'b0, idx_ff} + 3'd1) == cur_ff.count;
   assign xfer = valid_ff && !rsp_stall;
   assign load = q_valid && (!valid_ff || (xfer && last));

   assign q_pop        = load;
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = cur_ff.data[idx_ff];
   assign rsp_status   = cur_ff.status;
   assign rsp_last     = last;

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (xfer) begin
         if (last) begin
            valid_ff <= 1'b0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

endmodule

[src/json_string_unescape_utf8_top.sv]
// A byte's results pass through the record queue into the serializer register.
// Throughput: one input byte per cycle while the queue is not full; the output
// sends one result per cycle unless stalled, so a byte that decodes to k results
// holds the output until all k are sent and the queue absorbs the difference.
// Reset (synchronous, active high): decoder idle awaiting a quote, queue empty.
module json_string_unescape_utf8_top
   import jsu_pkg::*;
#(
   parameter int unsigned QueueDepth = JSU_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   logic    q_full;
   logic    q_push;
   rec_type q_push_rec;
   logic    q_pop;
   logic    q_valid;
   rec_type q_pop_rec;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_rec       (q_push_rec)
   );

   jsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_push_rec),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_rec  (q_pop_rec)
   );

   jsu_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_rec        (q_pop_rec),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

endmodule

[verif/jsu_decode_checker.sv]
module jsu_decode_checker
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_status,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending_count,
   output int         data_seen,
   output int         done_seen,
   output int         error_seen
);

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0D;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX_HI,
      MODE_WANT_BS,
      MODE_WANT_U,
      MODE_HEX_LO
   } decode_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
   } utf8_result_type;

   utf8_result_type utf8_expected[$];
   utf8_result_type want;

   decode_mode_type mode;
   logic [15:0]     hex_acc;
   logic [1:0]      hex_cnt;
   logic [9:0]      high_half;

   task automatic queue_result(input logic [7:0] b, input logic [1:0] st, input logic last);
      utf8_expected.push_back(utf8_result_type'{b, st, last});
   endtask

   task automatic close_string(input logic [1:0] st);
      mode      = MODE_IDLE;
      hex_acc   = '0;
      hex_cnt   = '0;
      high_half = '0;
      queue_result(8'h00, st, 1'b1);
   endtask

   task automatic queue_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         queue_result(cp[7:0], ST_DATA, 1'b1);
      end else if (cp < 21'h800) begin
         queue_result({3'b110, cp[10:6]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
      end else if (cp < 21'h10000) begin
         queue_result({4'b1110, cp[15:12]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[11:6]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
      end else begin
         queue_result({5'b11110, cp[20:18]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[17:12]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[11:6]}, ST_DATA, 1'b0);
         queue_result({2'b10, cp[5:0]}, ST_DATA, 1'b1);
      end
   endtask

   task automatic unescape_byte(input logic [7:0] b);
      logic [4:0]  nib;
      logic [15:0] v;
      logic [20:0] cp;
      case (mode)
         MODE_STR: begin
            if (b == CH_QUOTE) close_string(ST_DONE);
            else if (b == CH_BACKSLASH) mode = MODE_ESC;
            else if (b == CH_NUL) close_string(ST_ERROR);
            else queue_result(b, ST_DATA, 1'b1);
         end
         MODE_ESC: begin
            mode = MODE_STR;
            case (b)
               CH_QUOTE, CH_BACKSLASH, CH_SLASH: queue_result(b, ST_DATA, 1'b1);
               CH_B: queue_result(8'h08, ST_DATA, 1'b1);
               CH_F: queue_result(8'h0C, ST_DATA, 1'b1);
               CH_N: queue_result(8'h0A, ST_DATA, 1'b1);
               CH_R: queue_result(8'h0D, ST_DATA, 1'b1);
               CH_T: queue_result(8'h09, ST_DATA, 1'b1);
               CH_U: begin
                  mode    = MODE_HEX_HI;
                  hex_acc = '0;
                  hex_cnt = '0;
               end
               default: close_string(ST_ERROR);
            endcase
         end
         MODE_HEX_HI, MODE_HEX_LO: begin
            if (b >= "0" && b <= "9") nib = {1'b0, b[3:0]};
            else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
               nib = {1'b0, b[3:0] + 4'd9};
            else nib = 5'h10;
            if (nib[4]) begin
               close_string(ST_ERROR);
            end else begin
               v = {hex_acc[11:0], nib[3:0]};
               if (hex_cnt != 2'd3) begin
                  hex_acc = v;
                  hex_cnt++;
               end else begin
                  hex_acc = '0;
                  hex_cnt = '0;
                  if (mode == MODE_HEX_HI) begin
                     if (v >= 16'hD800 && v <= 16'hDBFF) begin
                        high_half = v[9:0];
                        mode      = MODE_WANT_BS;
                     end else if ((v >= 16'hDC00 && v <= 16'hDFFF) || v == 16'hFFFF) begin
                        close_string(ST_ERROR);
                     end else begin
                        mode = MODE_STR;
                        queue_code_point({5'b0, v});
                     end
                  end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                     close_string(ST_ERROR);
                  end else begin
                     cp = 21'h10000 + {high_half, v[9:0]};
                     if (cp[15:0] == 16'hFFFF) begin
                        close_string(ST_ERROR);
                     end else begin
                        high_half = '0;
                        mode      = MODE_STR;
                        queue_code_point(cp);
                     end
                  end
               end
            end
         end
         MODE_WANT_BS: begin
            if (b != CH_BACKSLASH) close_string(ST_ERROR);
            else mode = MODE_WANT_U;
         end
         MODE_WANT_U: begin
            if (b != CH_U) begin
               close_string(ST_ERROR);
            end else begin
               mode    = MODE_HEX_LO;
               hex_acc = '0;
               hex_cnt = '0;
            end
         end
         default: begin
            mode      = MODE_IDLE;
            hex_acc   = '0;
            hex_cnt   = '0;
            high_half = '0;
            if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
               if (b == CH_QUOTE) mode = MODE_STR;
               else close_string(ST_ERROR);
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         utf8_expected.delete();
         mode          = MODE_IDLE;
         hex_acc       = '0;
         hex_cnt       = '0;
         high_half     = '0;
         fail_count    = 0;
         pending_count = 0;
         data_seen     = 0;
         done_seen     = 0;
         error_seen    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (utf8_expected.size() == 0) begin
               $display("%0t: unexpected result: out_byte=%02h status=%0d last=%0b",
                        $time, rsp_out_byte, rsp_status, rsp_last);
               fail_count++;
            end else begin
               want = utf8_expected.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_status !== want.status ||
                   rsp_last !== want.last) begin
                  $display("%0t: expected %02h/%0d/%0b, actual %02h/%0d/%0b",
                           $time, want.out_byte, want.status, want.last,
                           rsp_out_byte, rsp_status, rsp_last);
                  fail_count++;
               end
            end
            case (rsp_status)
               ST_DATA: data_seen++;
               ST_DONE: done_seen++;
               default: error_seen++;
            endcase
         end
         if (req_valid && !req_stall) unescape_byte(req_in_byte);
         pending_count = utf8_expected.size();
      end
   end

endmodule

[verif/tb_top.sv]
module tb_top;
   import jsu_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 16;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_CR  = 8'h0D;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   int fail_count;
   int pending;
   int data_seen;
   int done_seen;
   int error_seen;

   int cycle_count = 0;
   int burst_left = 0;
   int sent_total = 0;
   int ignored_total = 0;
   int directed_total = 0;
   int strings_sent = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   json_string_unescape_utf8_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   jsu_decode_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending),
      .data_seen     (data_seen),
      .done_seen     (done_seen),
      .error_seen    (error_seen)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: phases of no stall, light stall and heavy stall
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  = $urandom_range(0, 2);
         stall_phase = $urandom_range(32, 256);
      end
      stall_phase--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return "0" + n;
      return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent_total++;
   endtask

   task automatic send_escape(input logic [7:0] c);
      send_byte(CH_BACKSLASH);
      send_byte(c);
   endtask

   task automatic send_u(input logic [15:0] v);
      send_escape(CH_U);
      for (int i = 3; i >= 0; i--) send_byte(hex_char(v[4*i +: 4]));
   endtask

   // hold off until every predicted result has been transferred
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_fault();
      int k;
      logic [7:0] b;
      logic [15:0] v;
      case ($urandom_range(0, 8))
         0: begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
            send_escape(b);
         end
         1: begin
            send_escape(CH_U);
            k = $urandom_range(0, 3);
            repeat (k) send_byte(hex_char(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255));
            while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
            send_byte(b);
         end
         2: send_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
         3: send_u(16'hFFFF);
         4: begin
            send_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            do b = 8'($urandom_range(0, 255));
            while (b == CH_BACKSLASH);
            send_byte(b);
         end
         5: begin
            send_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            do b = 8'($urandom_range(0, 255));
            while (b == CH_U);
            send_escape(b);
         end
         6: begin
            send_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            do v = 16'($urandom_range(0, 16'hFFFF));
            while (v inside {[16'hDC00:16'hDFFF]});
            send_u(v);
         end
         7: begin
            v = 16'hD83F | 16'($urandom_range(0, 15) << 6);
            send_u(v);
            send_u(16'hDFFF);
         end
         default: send_byte(CH_NUL);
      endcase
   endtask

   task automatic send_random_string();
      int kind;
      logic [7:0] b;
      logic [15:0] v;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            b = 8'($urandom_range(0, 5));
            send_byte(b == 8'd5 ? CH_SPACE : CH_TAB + b);
            ignored_total++;
         end
      end
      if ($urandom_range(0, 19) == 0) begin
         do b = 8'($urandom_range(0, 255));
         while (b == CH_QUOTE || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
         send_byte(b);
         return;
      end
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
         kind = $urandom_range(0, 19);
         if (kind == 15) begin
            send_fault();
            return;
         end else if (kind >= 6 && kind <= 8) begin
            case ($urandom_range(0, 7))
               0: send_escape(CH_QUOTE);
               1: send_escape(CH_BACKSLASH);
               2: send_escape(CH_SLASH);
               3: send_escape(CH_B);
               4: send_escape(CH_F);
               5: send_escape(CH_N);
               6: send_escape(CH_R);
               default: send_escape(CH_T);
            endcase
         end else if (kind >= 9 && kind <= 12) begin
            case ($urandom_range(0, 2))
               0: v = 16'($urandom_range(0, 16'h7F));
               1: v = 16'($urandom_range(16'h80, 16'h7FF));
               default: begin
                  do v = 16'($urandom_range(16'h800, 16'hFFFE));
                  while (v inside {[16'hD800:16'hDFFF]});
               end
            endcase
            send_u(v);
         end else if (kind == 13 || kind == 14) begin
            send_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            send_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
         end else begin
            do b = 8'($urandom_range(1, 255));
            while (b == CH_QUOTE || b == CH_BACKSLASH);
            send_byte(b);
         end
      end
      send_byte(CH_QUOTE);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // well-formed string covering every escape and each UTF-8 length
      send_byte(CH_TAB);
      send_byte(CH_CR);
      send_byte(CH_SPACE);
      send_byte(CH_QUOTE);
      send_byte(8'h01);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_escape(CH_QUOTE);
      send_escape(CH_BACKSLASH);
      send_escape(CH_SLASH);
      send_escape(CH_B);
      send_escape(CH_F);
      send_escape(CH_N);
      send_escape(CH_R);
      send_escape(CH_T);
      send_u(16'h0000);
      send_u(16'h07FF);
      send_u(16'hFFFD);
      send_u(16'hDBFF);
      send_u(16'hDFFE);
      send_u(16'hD800);
      send_u(16'hDC00);
      send_byte(CH_QUOTE);

      // error paths
      send_byte("x");
      send_byte(CH_NUL);
      send_byte(CH_QUOTE);
      send_escape("q");
      send_byte(CH_QUOTE);
      send_escape(CH_U);
      send_byte("1");
      send_byte("2");
      send_byte("G");
      send_byte(CH_QUOTE);
      send_u(16'hDC00);
      send_byte(CH_QUOTE);
      send_u(16'hFFFF);
      send_byte(CH_QUOTE);
      send_u(16'hD800);
      send_byte("x");
      send_byte(CH_QUOTE);
      send_u(16'hD800);
      send_escape("x");
      send_byte(CH_QUOTE);
      send_u(16'hD800);
      send_u(16'h0041);
      send_byte(CH_QUOTE);
      send_u(16'hDBFF);
      send_u(16'hDFFF);
      send_byte(CH_QUOTE);
      send_byte("a");
      send_byte(CH_NUL);
      drain();
      directed_total = sent_total;

      while (sent_total - ignored_total < directed_total + RANDOM_ITEMS) begin
         send_random_string();
         strings_sent++;
         if (strings_sent % 12 == 0) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d input bytes (%0d directed, %0d random strings) in %0d cycles.",
               sent_total, directed_total, strings_sent, cycle_count);
      $display("Checked %0d data bytes, %0d completed strings and %0d decode errors.",
               data_seen, done_seen, error_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
